// ===== hw/rtl/hcd_pkg.sv =====
// Shared types, codes and helpers for the chunked transfer decoder.
package hcd_pkg;

  localparam int HC_W = 5;

  localparam logic [HC_W-1:0] HEADER_LIMIT_RESET = 5'd12;
  localparam logic [7:0]      CH_CR = 8'h0D;
  localparam logic [7:0]      CH_LF = 8'h0A;

  localparam logic [1:0] ST_HEADER  = 2'd0;
  localparam logic [1:0] ST_PAYLOAD = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  localparam logic ADDR_HEADER_LIMIT = 1'b0;

  typedef enum logic [4:0] {
    PH_SIZE    = 5'b00001,
    PH_TRAILER = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/hcd_stream_if.sv =====
// Valid/ready channels for raw stream items and decoded result items.
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface

// ===== hw/rtl/http_chunked_decoder.sv =====
// HTTP chunked transfer decoder: strips size lines and trailers from a byte stream.
//
// Channels: stream carries one raw byte per item, or an end-of-input marker;
// result carries one item per stream item: a payload byte with status 1,
// or status 0 (header byte consumed), 2 (finished) or 3 (header too long).
// The APB port writes header_limit at address 0; write it only while idle.
//
// Path: a stream item is held in the input register; its result item is then
// written to the result register and leaves from there when result is ready.
// Throughput: one item per cycle unless result stalls; each byte's state update
// is a single pass through the decode logic between the input and result registers.
//
// Reset clears both registers' valid bits and returns to reading the first
// size line with header_limit 12. When result is stalled, the result register
// holds, the input register fills and then stream.ready drops until the
// result item is taken.
module http_chunked_decoder
  import hcd_pkg::*;
#(
  parameter int SIZE_BITS           = 40,
  parameter int HEADER_BUFFER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  hcd_in_if.sink      stream,
  hcd_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [HC_W:0] BUF_LIM = (HC_W+1)'(HEADER_BUFFER_BYTES);

  logic [HC_W-1:0] header_limit;

  logic       in_vld;
  logic [7:0] in_byte_q;
  logic       eoi_q;

  logic       out_vld;
  logic [7:0] out_byte_q;
  logic [1:0] status_q;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [HC_W-1:0]      header_count, header_count_next;
  logic                 is_first_chunk, is_first_chunk_next;
  logic [31:0]          last_four_bytes, last_four_bytes_next;
  logic [SIZE_BITS-1:0] hex_accumulator, hex_accumulator_next;
  logic                 digits_ended, digits_ended_next;
  logic [7:0]           ob_next;
  logic [1:0]           st_next;

  logic                 advance;
  logic [HC_W:0]        limit;
  logic [HC_W-1:0]      hc_inc;
  logic [31:0]          lfb_shift;
  logic [SIZE_BITS-1:0] acc_upd;
  logic [SIZE_BITS-1:0] rem_dec;
  hex_t                 hx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_HEADER_LIMIT) ? {27'd0, header_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= HEADER_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_HEADER_LIMIT) begin
      header_limit <= pwdata[HC_W-1:0];
    end
  end

  assign advance      = in_vld && (!out_vld || result.ready);
  assign stream.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (stream.ready) begin
      in_vld <= stream.valid;
    end
    if (stream.ready && stream.valid) begin
      in_byte_q <= stream.in_byte;
      eoi_q     <= stream.end_of_input;
    end
  end

  assign limit     = ({1'b0, header_limit} > BUF_LIM) ? BUF_LIM : {1'b0, header_limit};
  assign hc_inc    = header_count + 1'b1;
  assign lfb_shift = {last_four_bytes[23:0], in_byte_q};
  assign hx        = hex_digit(in_byte_q);
  assign rem_dec   = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;

  always_comb begin
    if (hex_accumulator[SIZE_BITS-1 -: 4] != 4'd0) begin
      acc_upd = '1;
    end else begin
      acc_upd = {hex_accumulator[SIZE_BITS-5:0], hx.value};
    end
  end

  always_comb begin
    phase_next           = phase;
    bytes_remaining_next = bytes_remaining;
    header_count_next    = header_count;
    is_first_chunk_next  = is_first_chunk;
    last_four_bytes_next = last_four_bytes;
    hex_accumulator_next = hex_accumulator;
    digits_ended_next    = digits_ended;
    ob_next              = 8'd0;
    st_next              = ST_HEADER;
    if (eoi_q) begin
      phase_next           = PH_DONE;
      header_count_next    = '0;
      last_four_bytes_next = '0;
      hex_accumulator_next = '0;
      digits_ended_next    = 1'b0;
      st_next              = ST_DONE;
    end else begin
      unique case (phase)
        PH_DONE: begin
          st_next = ST_DONE;
        end
        PH_ERROR: begin
          st_next = ST_TOOLONG;
        end
        PH_PAYLOAD: begin
          ob_next              = in_byte_q;
          st_next              = ST_PAYLOAD;
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next           = PH_SIZE;
            header_count_next    = '0;
            last_four_bytes_next = '0;
            hex_accumulator_next = '0;
            digits_ended_next    = 1'b0;
          end
        end
        PH_SIZE, PH_TRAILER: begin
          if ({1'b0, header_count} >= limit) begin
            phase_next = PH_ERROR;
            st_next    = ST_TOOLONG;
          end else begin
            header_count_next    = hc_inc;
            last_four_bytes_next = lfb_shift;
            if (phase == PH_SIZE) begin
              if ((is_first_chunk || header_count >= HC_W'(2)) && !digits_ended) begin
                if (!hx.ok) begin
                  digits_ended_next = 1'b1;
                end else begin
                  hex_accumulator_next = acc_upd;
                end
              end
              if (hc_inc > HC_W'(2) && lfb_shift[15:0] == {CH_CR, CH_LF}) begin
                if (hex_accumulator_next != '0) begin
                  bytes_remaining_next = hex_accumulator_next;
                  is_first_chunk_next  = 1'b0;
                  phase_next           = PH_PAYLOAD;
                  header_count_next    = '0;
                  last_four_bytes_next = '0;
                  hex_accumulator_next = '0;
                  digits_ended_next    = 1'b0;
                end else begin
                  phase_next = PH_TRAILER;
                end
              end
            end else if (hc_inc > HC_W'(4) && lfb_shift == {CH_CR, CH_LF, CH_CR, CH_LF}) begin
              phase_next = PH_DONE;
              st_next    = ST_DONE;
            end
          end
        end
        default: begin
          st_next = ST_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      bytes_remaining <= '0;
      header_count    <= '0;
      is_first_chunk  <= 1'b1;
      last_four_bytes <= '0;
      hex_accumulator <= '0;
      digits_ended    <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      header_count    <= header_count_next;
      is_first_chunk  <= is_first_chunk_next;
      last_four_bytes <= last_four_bytes_next;
      hex_accumulator <= hex_accumulator_next;
      digits_ended    <= digits_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
    if (advance) begin
      out_byte_q <= ob_next;
      status_q   <= st_next;
    end
  end

  assign result.valid    = out_vld;
  assign result.out_byte = out_byte_q;
  assign result.status   = status_q;

endmodule

// ===== bench/http_chunked_decoder_tb.sv =====
// Self-checking bench for the HTTP chunked decoder: chunked streams in, decoded items checked.
`timescale 1ns / 1ps

module http_chunked_decoder_tb;
  import hcd_pkg::*;

  localparam int SIZE_W = 40;
  localparam int HDR_BUF = 16;
  localparam int RUN_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1550;
  localparam logic [2:0] HDR_LIMIT_ADDR = 3'd0;
  localparam logic [SIZE_W-1:0] SIZE_ONES = '1;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] code;
  } dec_item_t;

  typedef enum int {END_TRAILER, END_OVERFLOW, END_TOO_LONG} ending_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  hcd_in_if  stream_ch ();
  hcd_out_if result_ch ();

  http_chunked_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  raw_item_t raw_bytes_q[$];
  dec_item_t decoded_q[$];

  // decoder state as predicted
  phase_t            dec_phase;
  logic [SIZE_W-1:0] dec_left;
  logic [4:0]        dec_hdr_cnt;
  logic              dec_first;
  logic [31:0]       dec_tail;
  logic [SIZE_W-1:0] dec_size;
  logic              dec_digits_done;
  logic [4:0]        dec_limit;

  int unsigned gen_limit;
  int unsigned raw_total;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned hold_left;
  int unsigned next_hold_at;
  int unsigned gap_left;
  int unsigned burst_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic void clear_line();
    dec_hdr_cnt = '0;
    dec_tail = '0;
    dec_size = '0;
    dec_digits_done = 1'b0;
  endfunction

  function automatic dec_item_t decode_step(input raw_item_t it);
    dec_item_t r;
    int unsigned lim;
    int unsigned pos;
    logic [3:0] nib;
    r.data = 8'd0;
    r.code = ST_HEADER;
    if (it.eoi) begin
      dec_phase = PH_DONE;
      clear_line();
      r.code = ST_DONE;
    end else if (dec_phase == PH_DONE) begin
      r.code = ST_DONE;
    end else if (dec_phase == PH_ERROR) begin
      r.code = ST_TOOLONG;
    end else if (dec_phase == PH_PAYLOAD) begin
      r.data = it.data;
      r.code = ST_PAYLOAD;
      if (dec_left != 0) dec_left = dec_left - 1;
      if (dec_left == 0) begin
        dec_phase = PH_SIZE;
        clear_line();
      end
    end else begin
      lim = (dec_limit > HDR_BUF) ? HDR_BUF : dec_limit;
      if (dec_hdr_cnt >= lim) begin
        dec_phase = PH_ERROR;
        r.code = ST_TOOLONG;
      end else begin
        pos = dec_hdr_cnt;
        dec_hdr_cnt = dec_hdr_cnt + 5'd1;
        dec_tail = {dec_tail[23:0], it.data};
        if (dec_phase == PH_SIZE) begin
          if ((dec_first || pos >= 2) && !dec_digits_done) begin
            if (!hex_nibble(it.data, nib)) begin
              dec_digits_done = 1'b1;
            end else if (dec_size > ((SIZE_ONES - SIZE_W'(nib)) >> 4)) begin
              dec_size = SIZE_ONES;
            end else begin
              dec_size = {dec_size[SIZE_W-5:0], nib};
            end
          end
          if (dec_hdr_cnt > 2 && dec_tail[15:0] == {CH_CR, CH_LF}) begin
            if (dec_size != 0) begin
              dec_left = dec_size;
              dec_first = 1'b0;
              dec_phase = PH_PAYLOAD;
              clear_line();
            end else begin
              dec_phase = PH_TRAILER;
            end
          end
        end else if (dec_hdr_cnt > 4 && dec_tail == {CH_CR, CH_LF, CH_CR, CH_LF}) begin
          dec_phase = PH_DONE;
          r.code = ST_DONE;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    raw_bytes_q.push_back('{data: b, eoi: 1'b0});
    raw_total++;
  endtask

  task automatic push_eoi();
    raw_bytes_q.push_back('{data: 8'($urandom_range(0, 255)), eoi: 1'b1});
    raw_total++;
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (raw_bytes_q.size() != 0 || decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HDR_LIMIT_ADDR;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dec_limit = v;
    gen_limit = v;
    @(negedge clk);
  endtask

  task automatic add_chunk(input int unsigned size);
    int unsigned room;
    int unsigned nd;
    int unsigned zeros;
    int unsigned ext_len;
    int i;
    logic [7:0] c;
    logic [7:0] prev;
    logic [3:0] v;
    room = ((gen_limit > HDR_BUF) ? HDR_BUF : gen_limit) - 4;
    nd = (size > 15) ? 2 : 1;
    if (nd > room) begin
      size = 1 + size % 15;
      nd = 1;
    end
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(0, room - nd) : 0;
    ext_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, room - nd - zeros) : 0;
    if ($urandom_range(0, 9) == 0) begin
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_crlf();
    end
    repeat (zeros) push_byte("0");
    for (i = nd; i > 0; i--) push_byte(hex_char(4'(size >> (4 * (i - 1)))));
    prev = 8'd0;
    for (i = 0; i < ext_len; i++) begin
      c = 8'($urandom_range(0, 255));
      if (i == 0) begin
        while (hex_nibble(c, v)) c = 8'($urandom_range(0, 255));
      end else if (prev == CH_CR && c == CH_LF) begin
        c = 8'h3B;
      end
      push_byte(c);
      prev = c;
    end
    push_crlf();
    repeat (size) begin
      case ($urandom_range(0, 15))
        0: push_byte(CH_CR);
        1: push_byte(CH_LF);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // sender: bursts of items with gaps in between
  always @(posedge clk) begin
    if (rst) begin
      stream_ch.valid <= 1'b0;
      gap_left = 0;
      burst_left = 8;
    end else begin
      if (stream_ch.valid && stream_ch.ready) decoded_q.push_back(decode_step(raw_bytes_q.pop_front()));
      if (!stream_ch.valid || stream_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          stream_ch.valid <= 1'b0;
        end else if (raw_bytes_q.size() != 0) begin
          stream_ch.valid <= 1'b1;
          stream_ch.in_byte <= raw_bytes_q[0].data;
          stream_ch.end_of_input <= raw_bytes_q[0].eoi;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                       $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
          end
        end else begin
          stream_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result item against the oldest prediction
  always @(posedge clk) begin : recv_side
    logic rdy;
    dec_item_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected item, status", 8'(result_ch.status), 8'd0);
        end else begin
          want = decoded_q.pop_front();
          if (result_ch.status !== want.code)
            report_mismatch("status", 8'(result_ch.status), 8'(want.code));
          if (result_ch.out_byte !== want.data)
            report_mismatch("out_byte", result_ch.out_byte, want.data);
        end
        results_seen <= results_seen + 1;
      end
      case (cycle_count[9:8])
        2'd0: rdy = 1'b1;
        2'd1: rdy = 1'($urandom_range(0, 1));
        2'd2: rdy = (cycle_count % 3) != 0;
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      result_ch.ready <= rdy && (hold_left == 0);
    end
  end

  // long receiver hold-off so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      next_hold_at <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= 150;
      next_hold_at <= next_hold_at + 700;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned size;
    int unsigned nz;
    int unsigned n;
    int i;
    logic [7:0] c;
    logic [7:0] first_payload[10];
    logic [7:0] second_payload[11];
    ending_t ending;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    stream_ch.valid = 1'b0;
    stream_ch.in_byte = 8'd0;
    stream_ch.end_of_input = 1'b0;
    result_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    raw_total = 0;
    dec_limit = HEADER_LIMIT_RESET;
    gen_limit = HEADER_LIMIT_RESET;
    dec_phase = PH_SIZE;
    dec_left = '0;
    dec_first = 1'b1;
    clear_line();
    first_payload = '{8'h00, 8'hFF, 8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h80, 8'h7F, 8'h55, 8'hAA};
    second_payload = '{8'h01, 8'hFE, 8'h30, 8'h39, 8'h41, 8'h46, 8'h61, 8'h66, 8'h0D,
                       8'h0D, 8'h0A};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first size line at the reset limit: leading zero, extension
    push_byte("0");
    push_byte("A");
    push_byte(";");
    push_byte("x");
    push_crlf();
    for (i = 0; i < 5; i++) push_byte(first_payload[i]);
    write_limit(5'd4);
    for (i = 5; i < 10; i++) push_byte(first_payload[i]);
    write_limit(5'd5);
    push_crlf();
    push_byte("b");
    push_crlf();
    foreach (second_payload[i]) push_byte(second_payload[i]);
    write_limit(5'd12);

    while (raw_total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 4))
          0: write_limit(5'd5);
          1: write_limit(5'd16);
          2: write_limit(5'd31);
          default: write_limit(5'($urandom_range(6, 15)));
        endcase
      end
      n = $urandom_range(0, 19);
      if (n < 14) size = $urandom_range(1, 16);
      else if (n < 19) size = $urandom_range(17, 64);
      else size = $urandom_range(65, 255);
      add_chunk(size);
    end

    ending = ending_t'($urandom_range(0, 2));
    case (ending)
      END_TRAILER: begin
        write_limit($urandom_range(0, 1) ? 5'd16 : 5'd31);
        push_crlf();
        nz = $urandom_range(0, 2);
        repeat (nz) push_byte("0");
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) push_byte((i == 0) ? 8'h3B : 8'($urandom_range("g", "z")));
        push_crlf();
        n = $urandom_range(0, 3);
        if (n != 0) begin
          repeat (n) push_byte(8'($urandom_range(8'h20, 8'h7E)));
          push_crlf();
        end
        push_crlf();
        push_eoi();
      end
      END_OVERFLOW: begin
        write_limit($urandom_range(0, 1) ? 5'd16 : 5'd31);
        push_crlf();
        push_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (11) push_byte(hex_char(4'($urandom_range(0, 15))));
        push_crlf();
        repeat ($urandom_range(20, 60)) push_byte(8'($urandom_range(0, 255)));
        push_eoi();
      end
      default: begin
        write_limit(5'($urandom_range(4, 16)));
        push_crlf();
        repeat (gen_limit + 2) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_CR) c = 8'h20;
          push_byte(c);
        end
        push_eoi();
      end
    endcase
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) push_eoi();
      else push_byte(8'($urandom_range(0, 255)));
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
